[rtl/core/mct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mct_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int TABLE_ADDR_BITS = 8;
    localparam int SH_DOWN         = FRAC_BITS - TABLE_ADDR_BITS;
    localparam int TSIZE           = 1 << TABLE_ADDR_BITS;
    localparam int IN_W            = FRAC_BITS + 1;
    localparam int OUT_W           = FRAC_BITS + 2;
    localparam int IDX_W           = TABLE_ADDR_BITS + 1;
    localparam int PROD_W          = IN_W + SH_DOWN;

    localparam logic [63:0] LOG_SCALE_K = 64'd538714161;

    localparam logic [IN_W-1:0]  ONE_V   = IN_W'(1) << FRAC_BITS;
    localparam logic [IN_W-1:0]  HALF_V  = ONE_V >> 1;
    localparam logic [OUT_W-1:0] ONE_W   = OUT_W'(ONE_V);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIPOLAR    = 2'd2;

    localparam logic [1:0] KIND_LINEAR  = 2'd0;
    localparam logic [1:0] KIND_SWITCH  = 2'd1;
    localparam logic [1:0] KIND_CONCAVE = 2'd2;
    localparam logic [1:0] KIND_CONVEX  = 2'd3;

    typedef logic [IN_W-1:0] t_rom [0:TSIZE];

    typedef struct packed {
        logic             log_sel;
        logic             convex;
        logic             neg;
        logic [OUT_W-1:0] lin;
    } t_ctrl;

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] lg;
        logic [63:0] d;
        logic [63:0] p;
        logic [63:0] v;
        int unsigned k;
        int unsigned n;
        for (int i = 0; i < TSIZE; i++) begin
            k    = TSIZE - i;
            n    = 0;
            frac = 64'd0;
            while ((k >> (n + 1)) != 0)
                n++;
            m = (64'(k) << 30) >> n;
            for (int b = 0; b < 32; b++) begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m       = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            lg = (64'(n) << 32) | frac;
            d  = (64'(TABLE_ADDR_BITS) << 32) - lg;
            p  = (d >> 8) * LOG_SCALE_K;
            v  = (p + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS);
            if (v > 64'(ONE_V))
                v = 64'(ONE_V);
            rom[i] = v[IN_W-1:0];
        end
        rom[TSIZE] = ONE_V;
        return rom;
    endfunction

    localparam t_rom CURVE_ROM = build_rom();

endpackage

`default_nettype wire

[rtl/core/mct_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mct_in_if;
    logic                     valid;
    logic                     ready;
    logic [mct_pkg::IN_W-1:0] control_value;

    modport source (output valid, output control_value, input ready);
    modport sink   (input valid, input control_value, output ready);
endinterface

interface mct_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [mct_pkg::OUT_W-1:0] shaped_value;

    modport source (output valid, output shaped_value, input ready);
    modport sink   (input valid, input shaped_value, output ready);
endinterface

interface mct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mct_pkg::CFG_IDX_W-1:0]  index;
    logic [mct_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mct_interp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mct_interp (
    input  wire logic                     i_clk,
    input  wire logic                     i_adv_lut,
    input  wire logic                     i_adv_mul,
    input  wire logic [mct_pkg::IN_W-1:0] i_arg,
    output logic      [mct_pkg::IN_W-1:0] o_curve
);

    logic [mct_pkg::IDX_W-1:0]   w_idx;
    logic [mct_pkg::IDX_W-1:0]   w_idx_nx;
    logic [mct_pkg::IN_W-1:0]    n_lo;
    logic [mct_pkg::IN_W-1:0]    n_hi;
    logic [mct_pkg::IN_W-1:0]    r_lo;
    logic [mct_pkg::IN_W-1:0]    r_hi;
    logic [mct_pkg::SH_DOWN-1:0] r_frac;
    logic [mct_pkg::IN_W-1:0]    w_diff;
    logic [mct_pkg::PROD_W-1:0]  w_prod;
    logic [mct_pkg::IN_W-1:0]    n_curve;
    logic [mct_pkg::IN_W-1:0]    r_curve;

    assign w_idx    = i_arg[mct_pkg::IN_W-1:mct_pkg::SH_DOWN];
    assign w_idx_nx = w_idx + mct_pkg::IDX_W'(1);

    always_comb begin
        n_lo = mct_pkg::CURVE_ROM[w_idx];
        n_hi = n_lo;
        if (!w_idx[mct_pkg::IDX_W-1])
            n_hi = mct_pkg::CURVE_ROM[w_idx_nx];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_lut) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_frac <= i_arg[mct_pkg::SH_DOWN-1:0];
        end
    end

    assign w_diff = r_hi - r_lo;
    assign w_prod = mct_pkg::PROD_W'(w_diff) * mct_pkg::PROD_W'(r_frac);

    always_comb begin
        if (r_hi < r_lo)
            n_curve = r_lo;
        else
            n_curve = r_lo + w_prod[mct_pkg::PROD_W-1:mct_pkg::SH_DOWN];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_mul)
            r_curve <= n_curve;
    end

    assign o_curve = r_curve;

endmodule

`default_nettype wire

[rtl/core/modulator_curve_transform_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Modulator curve transform: shapes one normalized control value (Q16, 1.0 = 65536)
// under the configured curve: linear, switch, concave or convex, with optional
// invert and bipolar mapping. The log curves come from an interpolated table.
// Channels: i_in carries control_value, o_out carries shaped_value (signed Q16),
// i_cfg writes the curve kind (index 0), invert (1) and bipolar (2) registers.
// Write configuration only while no item is in flight; a write is always taken.
// Pipeline: four register stages (prepare, table read, interpolation multiply, output
// register) lie between an input transfer and its result on o_out.
// Throughput: one item per cycle while o_out.ready is high; each stage holds a valid
// bit and the next item enters every cycle in which the pipeline is not stalled.
// Reset: i_rst_n low at a clock edge empties the pipeline and clears all
// configuration registers (linear, no invert, unipolar).
// Receiver stall: while o_out.ready is low the output holds; stages behind it
// keep filling until full, then i_in.ready drops. Nothing is lost or repeated.

module modulator_curve_transform_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mct_in_if.sink      i_in,
    mct_out_if.source   o_out,
    mct_cfg_if.sink     i_cfg
);

    logic [1:0] r_kind;
    logic       r_invert;
    logic       r_bipolar;

    logic r1_vld;
    logic r2_vld;
    logic r3_vld;
    logic r4_vld;
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;
    logic w_adv4;

    logic [mct_pkg::IN_W-1:0]  w_x_sat;
    logic [mct_pkg::IN_W-1:0]  w_x;
    logic [mct_pkg::IN_W-1:0]  w_y;
    logic [mct_pkg::OUT_W-1:0] w_v2;
    logic [mct_pkg::OUT_W-1:0] w_mag;
    logic [mct_pkg::IN_W-1:0]  n1_arg;
    logic [mct_pkg::IN_W-1:0]  r1_arg;
    mct_pkg::t_ctrl            n1_ctrl;
    mct_pkg::t_ctrl            r1_ctrl;
    mct_pkg::t_ctrl            r2_ctrl;
    mct_pkg::t_ctrl            r3_ctrl;
    logic [mct_pkg::IN_W-1:0]  w_curve;
    logic [mct_pkg::OUT_W-1:0] w_val;
    logic [mct_pkg::OUT_W-1:0] n4_out;
    logic [mct_pkg::OUT_W-1:0] r4_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= mct_pkg::KIND_LINEAR;
            r_invert  <= 1'b0;
            r_bipolar <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mct_pkg::CFG_CURVE_KIND: r_kind    <= i_cfg.data;
                mct_pkg::CFG_INVERT:     r_invert  <= i_cfg.data[0];
                mct_pkg::CFG_BIPOLAR:    r_bipolar <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_adv4     = !r4_vld || o_out.ready;
    assign w_adv3     = !r3_vld || w_adv4;
    assign w_adv2     = !r2_vld || w_adv3;
    assign w_adv1     = !r1_vld || w_adv2;
    assign i_in.ready = w_adv1;

    always_comb begin
        w_x_sat = (i_in.control_value > mct_pkg::ONE_V) ? mct_pkg::ONE_V
                                                         : i_in.control_value;
        w_x     = r_invert ? (mct_pkg::ONE_V - w_x_sat) : w_x_sat;
        w_y     = w_x;
        if (r_kind == mct_pkg::KIND_SWITCH)
            w_y = (w_x < mct_pkg::HALF_V) ? '0 : mct_pkg::ONE_V;
        w_v2    = {w_x, 1'b0};
        n1_ctrl.log_sel = r_kind[1];
        n1_ctrl.convex  = (r_kind == mct_pkg::KIND_CONVEX);
        n1_ctrl.neg     = r_bipolar && (w_v2 < mct_pkg::ONE_W);
        if (r_bipolar)
            n1_ctrl.lin = {w_y, 1'b0} - mct_pkg::ONE_W;
        else
            n1_ctrl.lin = mct_pkg::OUT_W'(w_y);
        if (!r_bipolar)
            w_mag = mct_pkg::OUT_W'(w_x);
        else if (n1_ctrl.neg)
            w_mag = mct_pkg::ONE_W - w_v2;
        else
            w_mag = w_v2 - mct_pkg::ONE_W;
        n1_arg = w_mag[mct_pkg::IN_W-1:0];
        if (n1_ctrl.convex)
            n1_arg = mct_pkg::ONE_V - w_mag[mct_pkg::IN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w_adv1)
                r1_vld <= i_in.valid;
            if (w_adv2)
                r2_vld <= r1_vld;
            if (w_adv3)
                r3_vld <= r2_vld;
            if (w_adv4)
                r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_arg  <= n1_arg;
            r1_ctrl <= n1_ctrl;
        end
        if (w_adv2)
            r2_ctrl <= r1_ctrl;
        if (w_adv3)
            r3_ctrl <= r2_ctrl;
        if (w_adv4)
            r4_out <= n4_out;
    end

    mct_interp u_interp (
        .i_clk     (i_clk),
        .i_adv_lut (w_adv2),
        .i_adv_mul (w_adv3),
        .i_arg     (r1_arg),
        .o_curve   (w_curve)
    );

    always_comb begin
        w_val = mct_pkg::OUT_W'(w_curve);
        if (r3_ctrl.convex)
            w_val = mct_pkg::OUT_W'(mct_pkg::ONE_V - w_curve);
        if (!r3_ctrl.log_sel)
            n4_out = r3_ctrl.lin;
        else if (r3_ctrl.neg)
            n4_out = '0 - w_val;
        else
            n4_out = w_val;
    end

    assign o_out.valid        = r4_vld;
    assign o_out.shaped_value = r4_out;

endmodule

`default_nettype wire

[tb/modulator_curve_transform_top_tb.sv]
`timescale 1ns / 1ps

module modulator_curve_transform_top_tb;
    import mct_pkg::*;

    localparam longint UNIT      = longint'(1) << FRAC_BITS;
    localparam longint HALF_UNIT = UNIT >> 1;
    localparam longint LOG2_K    = 538714161;
    localparam int     PER_PHASE = 38;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady = 1'b0;

    always #4 i_clk = ~i_clk;

    mct_in_if  in_if();
    mct_out_if out_if();
    mct_cfg_if cfg_if();

    modulator_curve_transform_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    class shape_scoreboard;
        longint                   curve_table [TSIZE+1];
        logic signed [OUT_W-1:0]  pending [$];
        logic [1:0]               curve_kind;
        bit                       invert_on;
        bit                       bipolar_on;
        int                       errors;

        function new();
            longint unsigned k, n, mant, lg_frac, diff, scaled, entry;
            for (int i = 0; i < TSIZE; i++) begin
                k       = TSIZE - i;
                n       = 0;
                lg_frac = 0;
                while ((k >> (n + 1)) != 0)
                    n++;
                mant = (k << 30) >> n;
                repeat (32) begin
                    mant    = (mant * mant) >> 30;
                    lg_frac = lg_frac << 1;
                    if (mant >= (64'd1 << 31)) begin
                        mant    = mant >> 1;
                        lg_frac = lg_frac | 64'd1;
                    end
                end
                diff   = (64'(TABLE_ADDR_BITS) << 32) - ((n << 32) | lg_frac);
                scaled = (diff >> 8) * LOG2_K;
                entry  = (scaled + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS);
                if (entry > UNIT)
                    entry = UNIT;
                curve_table[i] = longint'(entry);
            end
            curve_table[TSIZE] = UNIT;
            curve_kind = KIND_LINEAR;
            invert_on  = 1'b0;
            bipolar_on = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CURVE_KIND: curve_kind = data[1:0];
                CFG_INVERT:     invert_on  = data[0];
                CFG_BIPOLAR:    bipolar_on = data[0];
                default: ;
            endcase
        endfunction

        function longint concave_at(longint u);
            longint idx, frac, lo, hi;
            if (u > UNIT)
                u = UNIT;
            idx  = u >>> SH_DOWN;
            frac = u & ((longint'(1) << SH_DOWN) - 1);
            if (idx >= TSIZE)
                return curve_table[TSIZE];
            lo = curve_table[idx];
            hi = curve_table[idx + 1];
            if (hi < lo)
                return lo;
            return lo + (((hi - lo) * frac) >>> SH_DOWN);
        endfunction

        function longint log_curve_at(longint u);
            if (curve_kind == KIND_CONCAVE)
                return concave_at(u);
            return UNIT - concave_at(UNIT - u);
        endfunction

        function logic signed [OUT_W-1:0] shape(logic [IN_W-1:0] cv);
            longint x, y, v, r;
            x = (longint'(cv) > UNIT) ? UNIT : longint'(cv);
            if (invert_on)
                x = UNIT - x;
            if (curve_kind == KIND_LINEAR || curve_kind == KIND_SWITCH) begin
                if (curve_kind == KIND_LINEAR)
                    y = x;
                else
                    y = (x < HALF_UNIT) ? 0 : UNIT;
                r = bipolar_on ? 2 * y - UNIT : y;
            end else if (bipolar_on) begin
                v = 2 * x - UNIT;
                r = (v < 0) ? -log_curve_at(-v) : log_curve_at(v);
            end else begin
                r = log_curve_at(x);
            end
            return r[OUT_W-1:0];
        endfunction

        function void note_input(logic [IN_W-1:0] cv);
            pending.push_back(shape(cv));
        endfunction

        function void check_result(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (pending.size() == 0) begin
                $error("shaped_value: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("shaped_value: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    shape_scoreboard sb = new();

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 11);
    endfunction

    function automatic logic [IN_W-1:0] pick_control();
        case ($urandom_range(0, 9))
            0: return IN_W'($urandom_range(0, (1 << IN_W) - 1));
            1: return IN_W'($urandom_range(0, 700));
            2: return IN_W'($urandom_range(UNIT - 700, UNIT));
            3: return IN_W'($urandom_range(HALF_UNIT - 70, HALF_UNIT + 70));
            default: return IN_W'($urandom_range(0, UNIT));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.set_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.control_value);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.shaped_value);
        end
        out_if.ready <= !take_break();
    end

    task automatic send_control(input logic [IN_W-1:0] value);
        while (take_break()) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.control_value <= value;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic write_config(input logic [1:0] kind, input bit inv, input bit bip);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{CFG_CURVE_KIND, CFG_INVERT, CFG_BIPOLAR};
        vals = '{CFG_DATA_W'(kind), CFG_DATA_W'(inv), CFG_DATA_W'(bip)};
        for (int r = 0; r < 3; r++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[r];
            cfg_if.data  <= vals[r];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [IN_W-1:0] corner_values [6];
        logic [3:0]      combo;
        corner_values = '{IN_W'(0), IN_W'(HALF_V - 1), HALF_V, ONE_V, IN_W'(ONE_V + 1), '1};
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.control_value <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_CURVE_KIND;
        cfg_if.data         <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_values[j])
            send_control(corner_values[j]);
        settle();
        write_config(KIND_SWITCH, 1'b0, 1'b1);
        foreach (corner_values[j])
            send_control(corner_values[j]);
        settle();
        write_config(KIND_CONCAVE, 1'b1, 1'b0);
        foreach (corner_values[j])
            send_control(corner_values[j]);
        settle();
        write_config(KIND_CONVEX, 1'b0, 1'b1);
        foreach (corner_values[j])
            send_control(corner_values[j]);
        settle();

        for (int ph = 0; ph < 16; ph++) begin
            combo  = 4'((ph * 5 + 3) % 16);
            steady = (ph >= 5 && ph <= 7);
            write_config(combo[1:0], combo[2], combo[3]);
            repeat (PER_PHASE)
                send_control(pick_control());
            settle();
        end
        steady = 1'b0;

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #3ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
